// File: src/ssat_pkg.sv
// shared types and constants for the strongest signal address table
`timescale 1ns / 1ps
`default_nettype none

package ssat_pkg;

    localparam int AddrW     = 48;
    localparam int KindW     = 8;
    localparam int StrengthW = 8;
    localparam int CountW    = 4;

    typedef struct packed {
        logic [AddrW-1:0]            address;
        logic [KindW-1:0]            kind;
        logic signed [StrengthW-1:0] strength;
    } t_entry;

    // running best that walks down the chain of cells
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_token;

endpackage

`default_nettype wire

// File: src/ssat_cell.sv
// one table cell: holds an entry, matches addresses and passes the running best on
`timescale 1ns / 1ps
`default_nettype none

module ssat_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_occupied,
    input  wire logic                       i_wr,
    input  wire ssat_pkg::t_entry           i_entry,
    input  wire logic [ssat_pkg::AddrW-1:0] i_match_addr,
    output logic                            o_match,
    input  wire ssat_pkg::t_token           i_tok,
    output ssat_pkg::t_token                o_tok
);

    ssat_pkg::t_entry r_entry;
    ssat_pkg::t_token r_tok;
    ssat_pkg::t_token n_tok;

    assign o_match = i_occupied && (r_entry.address == i_match_addr);
    assign o_tok   = r_tok;

    // strictly stronger replaces, so the earlier cell keeps ties
    always_comb begin
        n_tok = i_tok;
        if (i_occupied && (!i_tok.valid ||
                (r_entry.strength > i_tok.entry.strength))) begin
            n_tok.valid = 1'b1;
            n_tok.entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

endmodule

`default_nettype wire

// File: src/strongest_signal_address_table.sv
// top level of the strongest signal address table
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to MAX_ENTRIES device candidates in a row of cells. An add beat
// updates the entry with the same address or appends a new one while there
// is room; a clear beat empties the table. Each input beat gives one result
// beat with the acceptance flag, the entry count and the strongest entry
// (earliest wins ties, all zero when empty). An item is taken in the idle
// state, matched and written in the update state, then the running best walks
// the chain one cell per cycle in the sweep state, and the result register
// loads in the done state. A new beat is taken as soon as the previous result
// is loaded, even while that result still waits downstream; the next result
// then holds in the done state until the waiting one is taken.
module strongest_signal_address_table #(
    parameter int MAX_ENTRIES   = 8,
    parameter int ADDRESS_BYTES = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_operation,
    input  wire logic [47:0] i_device_address,
    input  wire logic [7:0]  i_address_kind,
    input  wire logic signed [7:0] i_signal_strength,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_accepted,
    output logic [3:0]       o_entry_count,
    output logic             o_best_valid,
    output logic [47:0]      o_best_address,
    output logic [7:0]       o_best_kind,
    output logic signed [7:0] o_best_strength
);

    localparam int CntW   = $clog2(MAX_ENTRIES + 1);
    localparam int SweepW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [ssat_pkg::AddrW-1:0] AddrMask = (ADDRESS_BYTES >= 6) ?
        {ssat_pkg::AddrW{1'b1}} :
        ((ssat_pkg::AddrW'(1) << (8 * ADDRESS_BYTES)) - ssat_pkg::AddrW'(1));

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state            r_state;
    logic              r_op;
    ssat_pkg::t_entry  r_item;
    logic [CntW-1:0]   r_count;
    logic [SweepW-1:0] r_sweep;
    logic              r_accepted;

    logic              r_out_valid;
    logic              r_out_accepted;
    logic [CntW-1:0]   r_out_count;
    ssat_pkg::t_token  r_out_best;

    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_occupied;
    logic [MAX_ENTRIES-1:0] w_wr;
    ssat_pkg::t_token       w_tok [MAX_ENTRIES+1];

    logic w_hit;
    logic w_room;
    logic w_load;

    assign w_hit  = |w_match;
    assign w_room = (r_count < CntW'(MAX_ENTRIES));
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign w_tok[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign w_occupied[g] = (r_count > CntW'(g));
        assign w_wr[g] = (r_state == S_UPDATE) && !r_op &&
            (w_match[g] || (!w_hit && w_room && (r_count == CntW'(g))));

        ssat_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_occupied   (w_occupied[g]),
            .i_wr         (w_wr[g]),
            .i_entry      (r_item),
            .i_match_addr (r_item.address),
            .o_match      (w_match[g]),
            .i_tok        (w_tok[g]),
            .o_tok        (w_tok[g+1])
        );
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op            <= i_operation;
            r_item.address  <= i_device_address & AddrMask;
            r_item.kind     <= i_address_kind;
            r_item.strength <= i_signal_strength;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_sweep    <= '0;
            r_accepted <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_op) begin
                        r_count    <= '0;
                        r_accepted <= 1'b1;
                    end else begin
                        r_accepted <= w_hit || w_room;
                        if (!w_hit && w_room) begin
                            r_count <= r_count + CntW'(1);
                        end
                    end
                    r_sweep <= SweepW'(MAX_ENTRIES - 1);
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    // the sweep counts down over every cell so the tail token can settle
                    if (r_sweep == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sweep <= r_sweep - SweepW'(1);
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_accepted <= r_accepted;
            r_out_count    <= r_count;
            r_out_best     <= w_tok[MAX_ENTRIES].valid ? w_tok[MAX_ENTRIES] : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_accepted      = r_out_accepted;
    assign o_entry_count   = 4'(r_out_count);
    assign o_best_valid    = r_out_best.valid;
    assign o_best_address  = r_out_best.entry.address;
    assign o_best_kind     = r_out_best.entry.kind;
    assign o_best_strength = r_out_best.entry.strength;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for the strongest signal address table
`timescale 1ns / 1ps

module tb_top;

    import ssat_pkg::*;

    localparam int TableDepth = 8;
    localparam int AddrBytes  = 6;
    localparam int Latency    = TableDepth + 3;
    localparam int PoolSize   = 12;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [AddrW-1:0] ADDR_ONES = '1;

    typedef struct packed {
        logic                        accepted;
        logic [CountW-1:0]           entry_count;
        logic                        best_valid;
        logic [AddrW-1:0]            best_address;
        logic [KindW-1:0]            best_kind;
        logic signed [StrengthW-1:0] best_strength;
    } t_summary;

    // mirrors the candidate table and queues the summary each report should produce
    class candidate_board;
        t_entry      slots[TableDepth];
        int unsigned fill;
        t_summary    expected_summaries[$];
        int unsigned mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void note_report(logic op, logic [AddrW-1:0] address,
                                  logic [KindW-1:0] kind,
                                  logic signed [StrengthW-1:0] strength);
            logic [AddrW-1:0] key_mask;
            logic [AddrW-1:0] key;
            t_summary         sum;
            bit               hit;
            int               best;

            key_mask = (AddrBytes >= AddrW / 8) ? ADDR_ONES
                                                : (AddrW'(1) << (8 * AddrBytes)) - 1;
            key      = address & key_mask;
            sum      = '0;
            sum.accepted = 1'b1;
            hit      = 0;
            if (op == OP_CLEAR) begin
                fill = 0;
            end else begin
                for (int i = 0; i < fill; i++) begin
                    if (!hit && slots[i].address == key) begin
                        slots[i].kind     = kind;
                        slots[i].strength = strength;
                        hit = 1;
                    end
                end
                if (!hit) begin
                    if (fill >= TableDepth) begin
                        sum.accepted = 1'b0;
                    end else begin
                        slots[fill].address  = key;
                        slots[fill].kind     = kind;
                        slots[fill].strength = strength;
                        fill++;
                    end
                end
            end
            sum.entry_count = CountW'(fill);
            if (fill != 0) begin
                best = 0;
                // strict compare keeps the lowest index on a tie
                for (int i = 1; i < fill; i++) begin
                    if ($signed(slots[i].strength) > $signed(slots[best].strength)) begin
                        best = i;
                    end
                end
                sum.best_valid    = 1'b1;
                sum.best_address  = slots[best].address;
                sum.best_kind     = slots[best].kind;
                sum.best_strength = slots[best].strength;
            end
            expected_summaries.push_back(sum);
        endfunction

        function void check_summary(t_summary got);
            t_summary want;

            if (expected_summaries.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
                return;
            end
            want = expected_summaries.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                mismatches++;
            end
            if (got.best_valid !== want.best_valid) begin
                $error("best_valid: expected %0d, got %0d", want.best_valid, got.best_valid);
                mismatches++;
            end
            if (got.best_address !== want.best_address) begin
                $error("best_address: expected %h, got %h",
                       want.best_address, got.best_address);
                mismatches++;
            end
            if (got.best_kind !== want.best_kind) begin
                $error("best_kind: expected %h, got %h", want.best_kind, got.best_kind);
                mismatches++;
            end
            if (got.best_strength !== want.best_strength) begin
                $error("best_strength: expected %0d, got %0d",
                       want.best_strength, got.best_strength);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_summaries.size();
        endfunction
    endclass

    logic                        i_clk             = 1'b0;
    logic                        i_rst_n           = 1'b0;
    logic                        i_valid           = 1'b0;
    logic                        i_operation       = 1'b0;
    logic [AddrW-1:0]            i_device_address  = '0;
    logic [KindW-1:0]            i_address_kind    = '0;
    logic signed [StrengthW-1:0] i_signal_strength = '0;
    logic                        i_ready           = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic                        o_accepted;
    logic [CountW-1:0]           o_entry_count;
    logic                        o_best_valid;
    logic [AddrW-1:0]            o_best_address;
    logic [KindW-1:0]            o_best_kind;
    logic signed [StrengthW-1:0] o_best_strength;

    int send_idle = 0;
    int recv_idle = 0;

    logic [AddrW-1:0] address_pool[PoolSize];

    candidate_board board = new();

    strongest_signal_address_table #(
        .MAX_ENTRIES  (TableDepth),
        .ADDRESS_BYTES(AddrBytes)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_device_address (i_device_address),
        .i_address_kind   (i_address_kind),
        .i_signal_strength(i_signal_strength),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_accepted       (o_accepted),
        .o_entry_count    (o_entry_count),
        .o_best_valid     (o_best_valid),
        .o_best_address   (o_best_address),
        .o_best_kind      (o_best_kind),
        .o_best_strength  (o_best_strength)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.note_report(i_operation, i_device_address, i_address_kind,
                                  i_signal_strength);
            end
            if (o_valid && i_ready) begin
                board.check_summary({o_accepted, o_entry_count, o_best_valid,
                                     o_best_address, o_best_kind, o_best_strength});
            end
        end
    end

    function automatic logic [AddrW-1:0] any_address();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    task automatic send_report(logic op, logic [AddrW-1:0] address, logic [KindW-1:0] kind,
                               logic signed [StrengthW-1:0] strength);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_operation       <= op;
        i_device_address  <= address;
        i_address_kind    <= kind;
        i_signal_strength <= strength;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic refill_pool();
        foreach (address_pool[i]) address_pool[i] = any_address();
    endtask

    task automatic send_random_report();
        logic [AddrW-1:0]            address;
        logic signed [StrengthW-1:0] strength;
        int                          pick;

        if ($urandom_range(0, 15) == 0) begin
            send_report(OP_CLEAR, any_address(), 8'($urandom()), 8'($urandom()));
            if ($urandom_range(0, 1) == 0) refill_pool();
            return;
        end
        // pool is larger than the table so hits, inserts and rejects all show up
        if ($urandom_range(0, 3) != 0) address = address_pool[$urandom_range(0, PoolSize - 1)];
        else address = any_address();
        pick = $urandom_range(0, 7);
        case (pick)
            0: strength = -8'sd128;
            1: strength = 8'sd127;
            2: strength = 8'sd0;
            3: strength = -8'sd1;
            default: strength = 8'($urandom());
        endcase
        send_report(OP_ADD, address, 8'($urandom()), strength);
    endtask

    initial begin
        refill_pool();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 33;
        recv_idle = 52;

        // clear on an empty table, then ties, updates, full table and reject
        send_report(OP_CLEAR, ADDR_ONES, 8'hff, -8'sd1);
        send_report(OP_ADD, '0, 8'h00, -8'sd128);
        send_report(OP_ADD, ADDR_ONES, 8'hff, 8'sd127);
        send_report(OP_ADD, 48'h0000_5a5a_a5a5, 8'h5a, 8'sd127);
        send_report(OP_ADD, ADDR_ONES, 8'h11, -8'sd1);
        send_report(OP_ADD, 48'h8000_0000_0001, 8'h80, -8'sd128);
        send_report(OP_ADD, 48'h1234_5678_9abc, 8'h01, 8'sd0);
        send_report(OP_ADD, 48'h0000_0000_0001, 8'h7f, 8'sd126);
        send_report(OP_ADD, 48'h7fff_ffff_ffff, 8'hfe, -8'sd60);
        send_report(OP_ADD, 48'haaaa_aaaa_aaaa, 8'h55, 8'sd1);
        send_report(OP_ADD, 48'h5555_5555_5555, 8'haa, 8'sd127);
        send_report(OP_ADD, 48'h0123_4567_89ab, 8'h33, 8'sd100);
        send_report(OP_ADD, '0, 8'ha5, 8'sd127);
        send_report(OP_ADD, 48'h5a5a_0000_a5a5, 8'h5a, -8'sd127);
        send_report(OP_CLEAR, '0, 8'h00, 8'sd0);
        send_report(OP_ADD, ADDR_ONES, 8'hc3, 8'sd0);
        send_report(OP_ADD, ADDR_ONES, 8'h3c, -8'sd128);
        send_report(OP_CLEAR, 48'h0000_5a5a_a5a5, 8'h5a, 8'sd127);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle = 33; recv_idle = 52; end
                1: begin send_idle = 52; recv_idle = 33; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            repeat (667) send_random_report();
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (2 * Latency) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
